FILE: src/assert_macros.svh
// assertion macros shared by the rtl of the circle intersection block
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// implication checked at every clock edge outside reset
`define CCI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circle intersection: implication failed");

// condition that holds at every clock edge outside reset
`define CCI_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("circle intersection: invariant failed");

`else

`define CCI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CCI_ASSERT_ALWAYS(lbl, clk, rst_n, cond)

`endif

`endif

FILE: src/cci_pkg.sv
// shared types and constants of the circle intersection block
// no dependencies
`default_nettype none

package cci_pkg;

    localparam int STATUS_W = 2;

    // classification of the two circles
    typedef enum logic [STATUS_W-1:0] {
        ST_TWO_POINTS  = 2'd0,
        ST_TOO_FAR     = 2'd1,
        ST_CONTAINED   = 2'd2,
        ST_COINCIDENT  = 2'd3
    } status_t;

endpackage

`default_nettype wire

FILE: src/circle_circle_intersection.sv
// two-circle intersection: status and both meeting points per request
// uses cci_pkg, cci_isqrt, cci_div and assert_macros.svh
// pipeline of 6 setup stages, a square root of 2*COORD_WIDTH stages, 4 product
// stages, a divider of COORD_WIDTH+2 stages and the output register; one request
// per cycle when not stalled
// synchronous active-low reset clears the valid bits only
`default_nettype none
`include "assert_macros.svh"

module circle_circle_intersection #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_first_center_x,
    input  logic signed [COORD_WIDTH-1:0] s_first_center_y,
    input  logic        [COORD_WIDTH-2:0] s_first_radius,
    input  logic signed [COORD_WIDTH-1:0] s_second_center_x,
    input  logic signed [COORD_WIDTH-1:0] s_second_center_y,
    input  logic        [COORD_WIDTH-2:0] s_second_radius,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cci_pkg::STATUS_W-1:0]  m_status,
    output logic signed [COORD_WIDTH-1:0] m_point_a_x,
    output logic signed [COORD_WIDTH-1:0] m_point_a_y,
    output logic signed [COORD_WIDTH-1:0] m_point_b_x,
    output logic signed [COORD_WIDTH-1:0] m_point_b_y
);

    localparam int CW   = COORD_WIDTH;
    localparam int RW   = CW - 1;        // radius
    localparam int DW   = CW + 1;        // centre difference
    localparam int SQW  = 2 * CW;        // squares, radicand halves
    localparam int D2W  = 2 * CW + 1;    // squared distance
    localparam int KW   = 2 * CW + 2;    // r1^2 - r2^2 + d2
    localparam int SW   = 2 * CW;        // square root
    localparam int QW   = 4 * CW;        // radicand
    localparam int PW   = 2 * CW + 3;    // partial products
    localparam int NW   = 3 * CW + 4;    // numerators
    localparam int NUMW = NW + 1;        // rounded numerator magnitude
    localparam int QB   = CW + 1;        // quotient bits before clamping

    localparam logic signed [CW+2:0] SAT_HI = (CW+3)'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [CW+2:0] SAT_LO = -SAT_HI - (CW+3)'(1);

    typedef struct packed {
        cci_pkg::status_t        status;
        logic signed [CW-1:0]    x1;
        logic signed [CW-1:0]    y1;
        logic signed [DW-1:0]    dx;
        logic signed [DW-1:0]    dy;
        logic signed [KW-1:0]    k;
        logic [D2W-1:0]          d2;
    } side_t;

    typedef struct packed {
        cci_pkg::status_t        status;
        logic                    neg;
        logic signed [CW-1:0]    base;
    } dside_t;

    // whole pipeline advances together; it only holds when the output waits
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic v7_reg, v8_reg, v9_reg, v10_reg;
    logic v_sq;

    // stage 1: centre differences, radius sum and gap
    logic signed [CW-1:0] x1_p1_reg, y1_p1_reg;
    logic signed [DW-1:0] dx_p1_reg, dy_p1_reg;
    logic [RW-1:0]        r1_p1_reg, r2_p1_reg, gap_p1_reg;
    logic [CW-1:0]        span_p1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_p1_reg   <= s_first_center_x;
            y1_p1_reg   <= s_first_center_y;
            dx_p1_reg   <= DW'(s_second_center_x) - DW'(s_first_center_x);
            dy_p1_reg   <= DW'(s_second_center_y) - DW'(s_first_center_y);
            r1_p1_reg   <= s_first_radius;
            r2_p1_reg   <= s_second_radius;
            span_p1_reg <= CW'(s_first_radius) + CW'(s_second_radius);
            gap_p1_reg  <= (s_first_radius > s_second_radius) ?
                           (s_first_radius - s_second_radius) :
                           (s_second_radius - s_first_radius);
        end
    end

    // stage 2: the six squares
    logic signed [2*DW-1:0] dxsq_full, dysq_full;
    assign dxsq_full = dx_p1_reg * dx_p1_reg;
    assign dysq_full = dy_p1_reg * dy_p1_reg;

    logic signed [CW-1:0] x1_p2_reg, y1_p2_reg;
    logic signed [DW-1:0] dx_p2_reg, dy_p2_reg;
    logic [SQW-1:0]       dxsq_p2_reg, dysq_p2_reg, s2_p2_reg;
    logic [2*RW-1:0]      r1sq_p2_reg, r2sq_p2_reg, t2_p2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_p2_reg   <= x1_p1_reg;
            y1_p2_reg   <= y1_p1_reg;
            dx_p2_reg   <= dx_p1_reg;
            dy_p2_reg   <= dy_p1_reg;
            dxsq_p2_reg <= dxsq_full[SQW-1:0];
            dysq_p2_reg <= dysq_full[SQW-1:0];
            s2_p2_reg   <= span_p1_reg * span_p1_reg;
            r1sq_p2_reg <= r1_p1_reg * r1_p1_reg;
            r2sq_p2_reg <= r2_p1_reg * r2_p1_reg;
            t2_p2_reg   <= gap_p1_reg * gap_p1_reg;
        end
    end

    // stage 3: squared distance and difference of squared radii
    logic signed [CW-1:0]   x1_p3_reg, y1_p3_reg;
    logic signed [DW-1:0]   dx_p3_reg, dy_p3_reg;
    logic [D2W-1:0]         d2_p3_reg;
    logic signed [2*RW:0]   rdiff_p3_reg;
    logic [SQW-1:0]         s2_p3_reg;
    logic [2*RW-1:0]        t2_p3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_p3_reg    <= x1_p2_reg;
            y1_p3_reg    <= y1_p2_reg;
            dx_p3_reg    <= dx_p2_reg;
            dy_p3_reg    <= dy_p2_reg;
            d2_p3_reg    <= D2W'(dxsq_p2_reg) + D2W'(dysq_p2_reg);
            rdiff_p3_reg <= $signed({1'b0, r1sq_p2_reg}) - $signed({1'b0, r2sq_p2_reg});
            s2_p3_reg    <= s2_p2_reg;
            t2_p3_reg    <= t2_p2_reg;
        end
    end

    // stage 4: classification, chord offset term and the two radicand factors
    cci_pkg::status_t status_next;
    logic signed [KW-1:0] k_next;
    logic [D2W-1:0] qa_full, qb_full;

    always_comb begin
        if (d2_p3_reg > D2W'(s2_p3_reg)) begin
            status_next = cci_pkg::ST_TOO_FAR;
        end else if (d2_p3_reg < D2W'(t2_p3_reg)) begin
            status_next = cci_pkg::ST_CONTAINED;
        end else if (d2_p3_reg == '0) begin
            status_next = cci_pkg::ST_COINCIDENT;
        end else begin
            status_next = cci_pkg::ST_TWO_POINTS;
        end
    end

    assign k_next  = KW'(rdiff_p3_reg) + $signed(KW'(d2_p3_reg));
    assign qa_full = D2W'(s2_p3_reg) - d2_p3_reg;
    assign qb_full = d2_p3_reg - D2W'(t2_p3_reg);

    side_t          side_p4_reg;
    logic [SQW-1:0] qa_p4_reg, qb_p4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            side_p4_reg.status <= status_next;
            side_p4_reg.x1     <= x1_p3_reg;
            side_p4_reg.y1     <= y1_p3_reg;
            side_p4_reg.dx     <= dx_p3_reg;
            side_p4_reg.dy     <= dy_p3_reg;
            side_p4_reg.k      <= k_next;
            side_p4_reg.d2     <= d2_p3_reg;
            // both factors stay below 2^(2*CW) whenever the circles meet
            qa_p4_reg          <= qa_full[SQW-1:0];
            qb_p4_reg          <= qb_full[SQW-1:0];
        end
    end

    // stage 5: radicand as four half-width partial products
    side_t          side_p5_reg;
    logic [SQW-1:0] qhh_p5_reg, qhl_p5_reg, qlh_p5_reg, qll_p5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            side_p5_reg <= side_p4_reg;
            qhh_p5_reg  <= qa_p4_reg[SQW-1:CW] * qb_p4_reg[SQW-1:CW];
            qhl_p5_reg  <= qa_p4_reg[SQW-1:CW] * qb_p4_reg[CW-1:0];
            qlh_p5_reg  <= qa_p4_reg[CW-1:0]   * qb_p4_reg[SQW-1:CW];
            qll_p5_reg  <= qa_p4_reg[CW-1:0]   * qb_p4_reg[CW-1:0];
        end
    end

    // stage 6: radicand sum
    side_t         side_p6_reg;
    logic [QW-1:0] q_p6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            side_p6_reg <= side_p5_reg;
            q_p6_reg    <= (QW'(qhh_p5_reg) << (2 * CW))
                         + ((QW'(qhl_p5_reg) + QW'(qlh_p5_reg)) << CW)
                         + QW'(qll_p5_reg);
        end
    end

    // floor square root, one bit per stage
    logic [SW-1:0] root_sq;
    side_t         side_sq;

    cci_isqrt #(
        .SW     (SW),
        .SIDE_W ($bits(side_t))
    ) u_isqrt (
        .clk       (aclk),
        .rst_n     (aresetn),
        .en        (en),
        .in_valid  (v6_reg),
        .rad       (q_p6_reg),
        .side_i    (side_p6_reg),
        .out_valid (v_sq),
        .root      (root_sq),
        .side_o    (side_sq)
    );

    // stage 7: dx*k, dy*k, dx*s, dy*s split into half-width partial products
    logic signed [CW+1:0] k_lo;
    logic signed [CW:0]   k_hi, s_lo, s_hi;
    logic signed [PW-1:0] pkxh, pkxl, pkyh, pkyl, psxh, psxl, psyh, psyl;

    assign k_lo = $signed({1'b0, side_sq.k[CW:0]});
    assign k_hi = side_sq.k[KW-1:CW+1];
    assign s_lo = $signed({1'b0, root_sq[CW-1:0]});
    assign s_hi = $signed({1'b0, root_sq[SW-1:CW]});
    assign pkxh = side_sq.dx * k_hi;
    assign pkxl = side_sq.dx * k_lo;
    assign pkyh = side_sq.dy * k_hi;
    assign pkyl = side_sq.dy * k_lo;
    assign psxh = side_sq.dx * s_hi;
    assign psxl = side_sq.dx * s_lo;
    assign psyh = side_sq.dy * s_hi;
    assign psyl = side_sq.dy * s_lo;

    side_t                side_p7_reg;
    logic signed [PW-1:0] pkxh_p7_reg, pkxl_p7_reg, pkyh_p7_reg, pkyl_p7_reg;
    logic signed [PW-1:0] psxh_p7_reg, psxl_p7_reg, psyh_p7_reg, psyl_p7_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            side_p7_reg <= side_sq;
            pkxh_p7_reg <= pkxh;
            pkxl_p7_reg <= pkxl;
            pkyh_p7_reg <= pkyh;
            pkyl_p7_reg <= pkyl;
            psxh_p7_reg <= psxh;
            psxl_p7_reg <= psxl;
            psyh_p7_reg <= psyh;
            psyl_p7_reg <= psyl;
        end
    end

    // stage 8: recombine the four products
    side_t                side_p8_reg;
    logic signed [NW-1:0] kx_p8_reg, ky_p8_reg, sx_p8_reg, sy_p8_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            side_p8_reg <= side_p7_reg;
            kx_p8_reg   <= (NW'(pkxh_p7_reg) <<< (CW + 1)) + NW'(pkxl_p7_reg);
            ky_p8_reg   <= (NW'(pkyh_p7_reg) <<< (CW + 1)) + NW'(pkyl_p7_reg);
            sx_p8_reg   <= (NW'(psxh_p7_reg) <<< CW) + NW'(psxl_p7_reg);
            sy_p8_reg   <= (NW'(psyh_p7_reg) <<< CW) + NW'(psyl_p7_reg);
        end
    end

    // stage 9: the four numerators, lane order a.x, a.y, b.x, b.y
    side_t                side_p9_reg;
    logic signed [NW-1:0] n_p9_reg [4];

    always_ff @(posedge aclk) begin
        if (en) begin
            side_p9_reg <= side_p8_reg;
            n_p9_reg[0] <= kx_p8_reg + sy_p8_reg;
            n_p9_reg[1] <= ky_p8_reg - sx_p8_reg;
            n_p9_reg[2] <= kx_p8_reg - sy_p8_reg;
            n_p9_reg[3] <= ky_p8_reg + sx_p8_reg;
        end
    end

    // stage 10: sign and magnitude, plus half the divisor for round-half-away
    logic [NUMW-1:0] num_p10_reg [4];
    dside_t          dside_p10_reg [4];
    logic [D2W-1:0]  den_p10_reg;
    logic            v_lane [4];
    logic [QB-1:0]   quot_lane [4];
    logic            ovf_lane [4];
    dside_t          dside_lane [4];
    logic signed [CW-1:0] res_lane [4];

    always_ff @(posedge aclk) begin
        if (en) begin
            // twice d2 still fits d2's width whenever the circles meet
            den_p10_reg <= {side_p9_reg.d2[D2W-2:0], 1'b0};
        end
    end

    for (genvar i = 0; i < 4; i++) begin : g_lane
        logic            neg;
        logic [NW-1:0]   mag;
        logic [QB:0]     qmag;
        logic signed [CW+2:0] qsgn;
        logic signed [CW+2:0] sum;

        assign neg = n_p9_reg[i][NW-1];
        assign mag = neg ? $unsigned(-n_p9_reg[i]) : $unsigned(n_p9_reg[i]);

        always_ff @(posedge aclk) begin
            if (en) begin
                num_p10_reg[i]          <= NUMW'(mag) + NUMW'(side_p9_reg.d2);
                dside_p10_reg[i].status <= side_p9_reg.status;
                dside_p10_reg[i].neg    <= neg;
                dside_p10_reg[i].base   <= (i % 2 == 0) ? side_p9_reg.x1 : side_p9_reg.y1;
            end
        end

        cci_div #(
            .NUM_W  (NUMW),
            .DEN_W  (D2W),
            .QB     (QB),
            .SIDE_W ($bits(dside_t))
        ) u_div (
            .clk       (aclk),
            .rst_n     (aresetn),
            .en        (en),
            .in_valid  (v10_reg),
            .num       (num_p10_reg[i]),
            .den       (den_p10_reg),
            .side_i    (dside_p10_reg[i]),
            .out_valid (v_lane[i]),
            .quot      (quot_lane[i]),
            .ovf       (ovf_lane[i]),
            .side_o    (dside_lane[i])
        );

        // clamped quotient is large enough that saturation gives the same result
        assign qmag = ovf_lane[i] ? ((QB+1)'(1) << QB) : {1'b0, quot_lane[i]};
        assign qsgn = dside_lane[i].neg ? -$signed((CW+3)'(qmag)) : $signed((CW+3)'(qmag));
        assign sum  = (CW+3)'(dside_lane[i].base) + qsgn;

        always_comb begin
            if (dside_lane[i].status != cci_pkg::ST_TWO_POINTS) begin
                res_lane[i] = '0;
            end else if (sum > SAT_HI) begin
                res_lane[i] = SAT_HI[CW-1:0];
            end else if (sum < SAT_LO) begin
                res_lane[i] = SAT_LO[CW-1:0];
            end else begin
                res_lane[i] = sum[CW-1:0];
            end
        end
    end

    // valid bits of the front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end else if (en) begin
            v1_reg  <= s_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= v_sq;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
        end
    end

    // output register
    cci_pkg::status_t     m_status_reg;
    logic signed [CW-1:0] m_ax_reg, m_ay_reg, m_bx_reg, m_by_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v_lane[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_status_reg <= dside_lane[0].status;
            m_ax_reg     <= res_lane[0];
            m_ay_reg     <= res_lane[1];
            m_bx_reg     <= res_lane[2];
            m_by_reg     <= res_lane[3];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_point_a_x = m_ax_reg;
    assign m_point_a_y = m_ay_reg;
    assign m_point_b_x = m_bx_reg;
    assign m_point_b_y = m_by_reg;

    // no points reported unless the circles meet
    `CCI_ASSERT_IMP(a_points_zero, aclk, aresetn, m_valid && (m_status != cci_pkg::ST_TWO_POINTS), (m_point_a_x == '0) && (m_point_a_y == '0) && (m_point_b_x == '0) && (m_point_b_y == '0))
    // a waiting result blocks new requests
    `CCI_ASSERT_IMP(a_stall_blocks_input, aclk, aresetn, m_valid && !m_ready, !s_ready)
    // the four divider lanes move in lockstep
    `CCI_ASSERT_ALWAYS(a_lanes_lockstep, aclk, aresetn, (v_lane[0] == v_lane[1]) && (v_lane[0] == v_lane[2]) && (v_lane[0] == v_lane[3]))

endmodule

`default_nettype wire

FILE: src/cci_isqrt.sv
// pipelined integer square root, one result bit per register stage
// no dependencies
`default_nettype none

module cci_isqrt #(
    parameter int SW     = 48,
    parameter int SIDE_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2*SW-1:0]     rad,
    input  logic [SIDE_W-1:0]   side_i,
    output logic                out_valid,
    output logic [SW-1:0]       root,
    output logic [SIDE_W-1:0]   side_o
);

    localparam int RMW = SW + 3;

    logic              v_reg    [SW];
    logic [2*SW-1:0]   rad_reg  [SW];
    logic [RMW-1:0]    rem_reg  [SW];
    logic [SW-1:0]     root_reg [SW];
    logic [SIDE_W-1:0] side_reg [SW];

    for (genvar g = 0; g < SW; g++) begin : g_stage
        logic              p_v;
        logic [2*SW-1:0]   p_rad;
        logic [RMW-1:0]    p_rem;
        logic [SW-1:0]     p_root;
        logic [SIDE_W-1:0] p_side;
        logic [RMW-1:0]    cand;
        logic [RMW-1:0]    trial;
        logic              ge;

        if (g == 0) begin : g_first
            assign p_v    = in_valid;
            assign p_rad  = rad;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_side = side_i;
        end else begin : g_next
            assign p_v    = v_reg[g-1];
            assign p_rad  = rad_reg[g-1];
            assign p_rem  = rem_reg[g-1];
            assign p_root = root_reg[g-1];
            assign p_side = side_reg[g-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign cand  = {p_rem[RMW-3:0], p_rad[2*SW-1 -: 2]};
        assign trial = RMW'({p_root, 2'b01});
        assign ge    = cand >= trial;

        always_ff @(posedge clk) begin
            if (!rst_n) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= p_v;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                rad_reg[g]  <= p_rad << 2;
                rem_reg[g]  <= ge ? (cand - trial) : cand;
                root_reg[g] <= {p_root[SW-2:0], ge};
                side_reg[g] <= p_side;
            end
        end
    end

    assign out_valid = v_reg[SW-1];
    assign root      = root_reg[SW-1];
    assign side_o    = side_reg[SW-1];

endmodule

`default_nettype wire

FILE: src/cci_div.sv
// pipelined restoring divider with a bounded quotient and an overflow flag
// no dependencies
`default_nettype none

module cci_div #(
    parameter int NUM_W  = 77,
    parameter int DEN_W  = 49,
    parameter int QB     = 25,
    parameter int SIDE_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [NUM_W-1:0]    num,
    input  logic [DEN_W-1:0]    den,
    input  logic [SIDE_W-1:0]   side_i,
    output logic                out_valid,
    output logic [QB-1:0]       quot,
    output logic                ovf,
    output logic [SIDE_W-1:0]   side_o
);

    localparam int HI_W = NUM_W - QB;

    // entry stage: quotient overflows when the high part already reaches the divisor
    logic [HI_W-1:0]   num_hi;
    logic              v0_reg;
    logic [DEN_W-1:0]  rem0_reg;
    logic [QB-1:0]     low0_reg;
    logic [DEN_W-1:0]  den0_reg;
    logic              ovf0_reg;
    logic [SIDE_W-1:0] side0_reg;

    assign num_hi = num[NUM_W-1:QB];

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            rem0_reg  <= num_hi[DEN_W-1:0];
            low0_reg  <= num[QB-1:0];
            den0_reg  <= den;
            ovf0_reg  <= num_hi >= HI_W'(den);
            side0_reg <= side_i;
        end
    end

    logic              v_reg    [QB];
    logic [DEN_W-1:0]  rem_reg  [QB];
    logic [QB-1:0]     low_reg  [QB];
    logic [QB-1:0]     q_reg    [QB];
    logic [DEN_W-1:0]  den_reg  [QB];
    logic              ovf_reg  [QB];
    logic [SIDE_W-1:0] side_reg [QB];

    for (genvar g = 0; g < QB; g++) begin : g_stage
        logic              p_v;
        logic [DEN_W-1:0]  p_rem;
        logic [QB-1:0]     p_low;
        logic [QB-1:0]     p_q;
        logic [DEN_W-1:0]  p_den;
        logic              p_ovf;
        logic [SIDE_W-1:0] p_side;
        logic [DEN_W:0]    cand;
        logic [DEN_W:0]    diff;
        logic              ge;

        if (g == 0) begin : g_first
            assign p_v    = v0_reg;
            assign p_rem  = rem0_reg;
            assign p_low  = low0_reg;
            assign p_q    = '0;
            assign p_den  = den0_reg;
            assign p_ovf  = ovf0_reg;
            assign p_side = side0_reg;
        end else begin : g_next
            assign p_v    = v_reg[g-1];
            assign p_rem  = rem_reg[g-1];
            assign p_low  = low_reg[g-1];
            assign p_q    = q_reg[g-1];
            assign p_den  = den_reg[g-1];
            assign p_ovf  = ovf_reg[g-1];
            assign p_side = side_reg[g-1];
        end

        assign cand = {p_rem, p_low[QB-1]};
        assign diff = cand - {1'b0, p_den};
        assign ge   = cand >= {1'b0, p_den};

        always_ff @(posedge clk) begin
            if (!rst_n) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= p_v;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[g]  <= ge ? diff[DEN_W-1:0] : cand[DEN_W-1:0];
                low_reg[g]  <= p_low << 1;
                q_reg[g]    <= {p_q[QB-2:0], ge};
                den_reg[g]  <= p_den;
                ovf_reg[g]  <= p_ovf;
                side_reg[g] <= p_side;
            end
        end
    end

    assign out_valid = v_reg[QB-1];
    assign quot      = q_reg[QB-1];
    assign ovf       = ovf_reg[QB-1];
    assign side_o    = side_reg[QB-1];

endmodule

`default_nettype wire
